// ===== sv/tiled_texture_detile_decode_core_assert.svh =====
// Assertion helpers for the texture detile core checker.
`ifndef TILED_TEXTURE_DETILE_DECODE_CORE_ASSERT_SVH
`define TILED_TEXTURE_DETILE_DECODE_CORE_ASSERT_SVH

// Implication checked out of reset.
`define TDD_ASSERT_RUN(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdd check failed");

// Next-cycle implication checked at every edge, reset included.
`define TDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tdd check failed");

`endif

// ===== sv/tdd_pkg.sv =====
// ----------------------------------------------------------------------------
// tdd_pkg
// Shared codes, types and pixel conversion functions of the detile core.
// ----------------------------------------------------------------------------
package tdd_pkg;

  localparam int NLANES = 16;

  localparam logic [3:0] FMT_I4     = 4'd0;
  localparam logic [3:0] FMT_I8     = 4'd1;
  localparam logic [3:0] FMT_IA4    = 4'd2;
  localparam logic [3:0] FMT_IA8    = 4'd3;
  localparam logic [3:0] FMT_RGB565 = 4'd4;
  localparam logic [3:0] FMT_RGB5A3 = 4'd5;
  localparam logic [3:0] FMT_RGBA8  = 4'd6;
  localparam logic [3:0] FMT_C4     = 4'd8;
  localparam logic [3:0] FMT_C8     = 4'd9;
  localparam logic [3:0] FMT_C14    = 4'd10;
  localparam logic [3:0] FMT_DXT1   = 4'd14;

  localparam logic [1:0] CMD_PAL   = 2'd0;
  localparam logic [1:0] CMD_CHUNK = 2'd1;
  localparam logic [1:0] CMD_BEGIN = 2'd2;

  localparam logic [1:0] PFMT_IA8    = 2'd0;
  localparam logic [1:0] PFMT_RGB565 = 2'd1;
  localparam logic [1:0] PFMT_RGB5A3 = 2'd2;

  localparam logic [1:0] REG_TEXEL  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_PFMT   = 2'd3;

  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_PAL    = 2'd1,
    KIND_R5A3   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [3:0]  fmt;
    logic [10:0] left;
    logic [10:0] top;
    logic [10:0] w;
    logic [10:0] h;
    logic [2:0]  k;
  } geom_t;

  typedef struct packed {
    logic        vld;
    logic [19:0] idx;
    kind_t       kind;
    logic [63:0] raw;
  } lane_res_t;

  function automatic logic [31:0] expand_rgb5a3(input logic [15:0] p);
    logic [7:0] a, r, g, b;
    if (p[15]) begin
      a = 8'hff;
      r = {p[14:10], p[14:12]};
      g = {p[9:5], p[9:7]};
      b = {p[4:0], p[4:2]};
    end else begin
      a = {p[14:12], p[14:12], p[14:13]};
      r = {p[11:8], p[11:8]};
      g = {p[7:4], p[7:4]};
      b = {p[3:0], p[3:0]};
    end
    return {a, r, g, b};
  endfunction

  function automatic logic [7:0] rev_pairs(input logic [7:0] b);
    return {b[1:0], b[3:2], b[5:4], b[7:6]};
  endfunction

endpackage

// ===== sv/tdd_ram.sv =====
// ----------------------------------------------------------------------------
// tdd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tdd_lane.sv =====
// ----------------------------------------------------------------------------
// tdd_lane
// One decode lane: position, bounds test and raw value of one chunk element.
// ----------------------------------------------------------------------------
module tdd_lane #(
  parameter int LANE = 0
) (
  input  tdd_pkg::geom_t    geo,
  input  logic [63:0]       chunk,
  input  logic [15:0]       hold_word,
  output tdd_pkg::lane_res_t res
);
  import tdd_pkg::*;

  logic [3:0]  nib;
  logic [7:0]  byt;
  logic [15:0] wd;
  logic [11:0] x, y;
  logic [10:0] bw, bh;
  logic        act;
  logic [22:0] lin;
  kind_t       kind;
  logic [63:0] raw;

  assign nib = 4'(chunk >> (60 - 4 * LANE));
  assign byt = 8'(chunk >> (56 - 8 * (LANE % 8)));
  assign wd  = 16'(chunk >> (48 - 16 * (LANE % 4)));

  always_comb begin
    act  = 1'b0;
    x    = {1'b0, geo.left};
    y    = {1'b0, geo.top};
    bw   = geo.w;
    bh   = geo.h;
    kind = KIND_DIRECT;
    raw  = '0;
    unique case (geo.fmt)
      FMT_I4, FMT_C4: begin
        act = 1'b1;
        x   = {1'b0, geo.left} + 12'(LANE % 8);
        y   = {1'b0, geo.top} + {8'd0, geo.k[1:0], 1'b0} + 12'(LANE / 8);
        if (geo.fmt == FMT_C4) begin
          kind = KIND_PAL;
          raw  = {60'd0, nib};
        end else begin
          raw = {56'd0, nib, nib};
        end
      end
      FMT_I8, FMT_IA4, FMT_C8: begin
        act = (LANE < 8);
        x   = {1'b0, geo.left} + 12'(LANE % 8);
        y   = {1'b0, geo.top} + {10'd0, geo.k[1:0]};
        raw = {56'd0, byt};
        if (geo.fmt == FMT_C8) kind = KIND_PAL;
      end
      FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_C14: begin
        act = (LANE < 4);
        x   = {1'b0, geo.left} + 12'(LANE % 4);
        y   = {1'b0, geo.top} + {10'd0, geo.k[1:0]};
        if (geo.fmt == FMT_C14) begin
          kind = KIND_PAL;
          raw  = {50'd0, wd[13:0]};
        end else begin
          raw = {48'd0, wd};
          if (geo.fmt == FMT_RGB5A3) kind = KIND_R5A3;
        end
      end
      FMT_RGBA8: begin
        act = (LANE < 4) && geo.k[2];
        x   = {1'b0, geo.left} + 12'(LANE % 4);
        y   = {1'b0, geo.top} + {10'd0, geo.k[1:0]};
        raw = {32'd0, hold_word, wd};
      end
      FMT_DXT1: begin
        act = (LANE == 0);
        bw  = 11'((12'(geo.w) + 12'd3) >> 2);
        bh  = 11'((12'(geo.h) + 12'd3) >> 2);
        x   = {3'd0, geo.left[10:2]} + {11'd0, geo.k[0]};
        y   = {3'd0, geo.top[10:2]} + {11'd0, geo.k[1]};
        raw = {chunk[55:48], chunk[63:56], chunk[39:32], chunk[47:40],
               rev_pairs(chunk[31:24]), rev_pairs(chunk[23:16]),
               rev_pairs(chunk[15:8]), rev_pairs(chunk[7:0])};
      end
      default: act = 1'b0;
    endcase
  end

  assign lin = 23'(y[10:0]) * 23'(bw) + 23'(x);
  assign res = '{vld:  act && (x < {1'b0, bw}) && (y < {1'b0, bh}),
                 idx:  lin[19:0],
                 kind: kind,
                 raw:  raw};

endmodule

// ===== sv/tiled_texture_detile_decode_core.sv =====
// Stages: lane bank, palette read stage, output register, passed in that order.
// Throughput: one pixel per cycle out of the merge stage while the output is not
// stalled; a chunk gives one pixel per visible lane (at most 16 for i4/c4, 8 for
// 8-bit, 4 for 16-bit, 1 for dxt1), issued via the single palette read port.
// Reset: synchronous active-low rst_n clears counters, config and pipe valids;
// palette and AR hold contents are undefined until written.
// ----------------------------------------------------------------------------
// tiled_texture_detile_decode_core
// Sixteen decode lanes per source chunk, merged into one pixel stream.
// ----------------------------------------------------------------------------
module tiled_texture_detile_decode_core #(
  parameter int MAX_DIM       = 1024,
  parameter int PALETTE_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [13:0] in_palette_index,
  input  logic [15:0] in_palette_value,
  input  logic [63:0] in_source_chunk,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_pixel_index,
  output logic [63:0] out_pixel_value,
  output logic        out_last
);
  import tdd_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [3:0]  texel_format_r;
  logic [10:0] image_width_r, image_height_r;
  logic [1:0]  palette_format_r;
  logic [10:0] tile_left_r, tile_top_r;
  logic [2:0]  chunk_in_tile_r;
  logic [63:0] hold_r [4];

  logic [10:0] w, h;
  logic        fmt_ok, in_acc, run;
  logic [2:0]  kk, k_inc, nch;
  logic [10:0] tw, th;
  logic [11:0] left_adv;
  geom_t       geo;
  logic [63:0] hrow;

  lane_res_t   lane_w [NLANES];
  lane_res_t   lane_r [NLANES];
  logic [NLANES-1:0] mask_r;
  logic [$clog2(NLANES)-1:0] sel;
  logic [NLANES-1:0] sel_oh;
  logic        issue, a_last, o_free, b_adv, b_free;

  logic        b_vld_r, b_last_r, b_oob_r;
  kind_t       b_kind_r;
  logic [19:0] b_idx_r;
  logic [63:0] b_raw_r;
  logic [15:0] pal_q;
  logic [15:0] pal_e;
  logic [63:0] conv;
  logic        out_valid_r;

  // effective dimensions
  always_comb begin
    if (image_width_r == 11'd0) w = 11'd1;
    else if (32'(image_width_r) > MAX_DIM) w = 11'(MAX_DIM);
    else w = image_width_r;
    if (image_height_r == 11'd0) h = 11'd1;
    else if (32'(image_height_r) > MAX_DIM) h = 11'(MAX_DIM);
    else h = image_height_r;
  end

  always_comb begin
    fmt_ok = 1'b1;
    tw     = 11'd4;
    th     = 11'd4;
    unique case (texel_format_r)
      FMT_I4, FMT_C4, FMT_DXT1: begin tw = 11'd8; th = 11'd8; end
      FMT_I8, FMT_IA4, FMT_C8:  tw = 11'd8;
      FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_C14, FMT_RGBA8: tw = 11'd4;
      default: fmt_ok = 1'b0;
    endcase
  end

  assign nch      = (texel_format_r == FMT_RGBA8) ? 3'd0 : 3'd4; // 0 means eight
  assign kk       = (texel_format_r == FMT_RGBA8) ? chunk_in_tile_r
                                                  : {1'b0, chunk_in_tile_r[1:0]};
  assign k_inc    = kk + 3'd1;
  assign left_adv = {1'b0, tile_left_r} + {1'b0, tw};

  // accept new beats once the lane bank is empty or draining its final pixel
  assign in_stall = (|mask_r) && !(issue && a_last);
  assign in_acc   = in_valid && !in_stall;
  assign run      = in_acc && (in_cmd == CMD_CHUNK) && fmt_ok && (tile_top_r < h);

  assign geo  = '{fmt: texel_format_r, left: tile_left_r, top: tile_top_r,
                  w: w, h: h, k: kk};
  assign hrow = hold_r[kk[1:0]];

  for (genvar g = 0; g < NLANES; g++) begin : g_lane
    tdd_lane #(.LANE(g)) u_lane (
      .geo       (geo),
      .chunk     (in_source_chunk),
      .hold_word (hrow[16*(g%4) +: 16]),
      .res       (lane_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      texel_format_r   <= FMT_I4;
      image_width_r    <= 11'd1;
      image_height_r   <= 11'd1;
      palette_format_r <= PFMT_IA8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXEL:  texel_format_r   <= cfg_data[3:0];
        REG_WIDTH:  image_width_r    <= cfg_data;
        REG_HEIGHT: image_height_r   <= cfg_data;
        REG_PFMT:   palette_format_r <= cfg_data[1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_left_r     <= '0;
      tile_top_r      <= '0;
      chunk_in_tile_r <= '0;
    end else if (in_acc && in_cmd == CMD_BEGIN) begin
      tile_left_r     <= '0;
      tile_top_r      <= '0;
      chunk_in_tile_r <= '0;
    end else if (run) begin
      if (k_inc == nch) begin
        chunk_in_tile_r <= '0;
        if (left_adv >= {1'b0, w}) begin
          tile_left_r <= '0;
          tile_top_r  <= tile_top_r + th;
        end else begin
          tile_left_r <= left_adv[10:0];
        end
      end else begin
        chunk_in_tile_r <= k_inc;
      end
    end
  end

  // AR rows of an rgba8 tile wait here for their GB rows
  always_ff @(posedge clk) begin
    if (run && texel_format_r == FMT_RGBA8 && !kk[2]) begin
      hold_r[kk[1:0]] <= {in_source_chunk[15:0], in_source_chunk[31:16],
                          in_source_chunk[47:32], in_source_chunk[63:48]};
    end
  end

  // merge: walk the visible lanes lowest first
  always_comb begin
    sel = '0;
    for (int i = NLANES - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = ($clog2(NLANES))'(i);
    end
  end

  assign sel_oh = NLANES'(1) << sel;
  assign a_last = ((mask_r & ~sel_oh) == '0);
  assign o_free = !out_valid_r || !out_stall;
  assign b_adv  = b_vld_r && o_free;
  assign b_free = !b_vld_r || b_adv;
  assign issue  = (|mask_r) && b_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (run) begin
      for (int i = 0; i < NLANES; i++) mask_r[i] <= lane_w[i].vld;
    end else if (issue) begin
      mask_r <= mask_r & ~sel_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      for (int i = 0; i < NLANES; i++) lane_r[i] <= lane_w[i];
    end
  end

  tdd_ram #(.WIDTH(16), .DEPTH(PALETTE_DEPTH)) u_pal (
    .clk   (clk),
    .we    (in_acc && in_cmd == CMD_PAL && (32'(in_palette_index) < PALETTE_DEPTH)),
    .waddr (AW'(in_palette_index)),
    .wdata (in_palette_value),
    .re    (issue),
    .raddr (AW'(lane_r[sel].raw[13:0])),
    .rdata (pal_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_free) begin
      b_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_idx_r  <= lane_r[sel].idx;
      b_kind_r <= lane_r[sel].kind;
      b_raw_r  <= lane_r[sel].raw;
      b_last_r <= a_last;
      b_oob_r  <= (32'(lane_r[sel].raw[13:0]) >= PALETTE_DEPTH);
    end
  end

  assign pal_e = b_oob_r ? 16'd0 : pal_q;

  always_comb begin
    conv = b_raw_r;
    unique case (b_kind_r)
      KIND_DIRECT: conv = b_raw_r;
      KIND_R5A3:   conv = {32'd0, expand_rgb5a3(b_raw_r[15:0])};
      KIND_PAL: begin
        unique case (palette_format_r)
          PFMT_IA8, PFMT_RGB565: conv = {48'd0, pal_e};
          PFMT_RGB5A3:           conv = {32'd0, expand_rgb5a3(pal_e)};
          default:               conv = '0;
        endcase
      end
      default: conv = b_raw_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_free) begin
      out_valid_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_pixel_index <= b_idx_r;
      out_pixel_value <= conv;
      out_last        <= b_last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/tdd_checker.sv =====
// ----------------------------------------------------------------------------
// tdd_checker
// Port-level checks of the detile core, bound to the top level.
// ----------------------------------------------------------------------------
`include "tiled_texture_detile_decode_core_assert.svh"

module tdd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_pixel_value
);

  // hold a stalled result beat
  `TDD_ASSERT_NEXT(a_out_hold, rst_n && out_valid && out_stall, !rst_n || out_valid)
  `TDD_ASSERT_RUN(a_out_stable, $past(rst_n && out_valid && out_stall) && out_valid, $stable(out_pixel_value))
  // reset empties the merge pipe and lane bank
  `TDD_ASSERT_NEXT(a_rst_out, !rst_n, !out_valid)
  `TDD_ASSERT_NEXT(a_rst_in, !rst_n, !in_stall)

endmodule

bind tiled_texture_detile_decode_core tdd_checker u_tdd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_value (out_pixel_value)
);

// ===== dv/tiled_texture_detile_decode_core_tb.sv =====
// ----------------------------------------------------------------------------
// tiled_texture_detile_decode_core_tb
// Drives palette loads and tiled source chunks in every texel format through
// the detile core and checks each output pixel beat against a software
// decode of the same stream. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tiled_texture_detile_decode_core_tb;
  import tdd_pkg::*;

  class pixel_scoreboard;
    typedef struct {
      bit [19:0] idx;
      bit [63:0] val;
      bit        last;
    } pix_t;

    pix_t      due[$];
    int        errors;
    bit [3:0]  fmt;
    bit [10:0] wreg, hreg;
    bit [1:0]  pfmt;
    int        left, top, k;
    bit [15:0] hold[16];
    bit [15:0] hold_seen;
    bit [15:0] pal[16384];

    function new();
      fmt = FMT_I4; wreg = 1; hreg = 1; pfmt = PFMT_IA8;
      left = 0; top = 0; k = 0; errors = 0; hold_seen = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(bit [1:0] r, bit [10:0] d);
      case (r)
        REG_TEXEL:  fmt = d[3:0];
        REG_WIDTH:  wreg = d;
        REG_HEIGHT: hreg = d;
        REG_PFMT:   pfmt = d[1:0];
      endcase
    endfunction

    function int dim(bit [10:0] v);
      if (v == 0) return 1;
      if (v > 1024) return 1024;
      return v;
    endfunction

    function bit [31:0] widen5a3(bit [15:0] p);
      bit [7:0] a, r, g, b;
      bit [2:0] a3;
      if (p[15]) begin
        a = 8'hff;
        r = (p[14:10] << 3) | (p[14:10] >> 2);
        g = (p[9:5] << 3) | (p[9:5] >> 2);
        b = (p[4:0] << 3) | (p[4:0] >> 2);
      end else begin
        a3 = p[14:12];
        a = (a3 << 5) | (a3 << 2) | (a3 >> 1);
        r = p[11:8] * 8'h11;
        g = p[7:4] * 8'h11;
        b = p[3:0] * 8'h11;
      end
      return {a, r, g, b};
    endfunction

    function bit [63:0] lookup(int i);
      case (pfmt)
        PFMT_IA8, PFMT_RGB565: return pal[i];
        PFMT_RGB5A3:           return widen5a3(pal[i]);
        default:               return 0;
      endcase
    endfunction

    function bit [7:0] flip_pairs(bit [7:0] b);
      bit [7:0] o;
      for (int j = 0; j < 4; j++) o[2*j +: 2] = b[6-2*j +: 2];
      return o;
    endfunction

    function void place(int x, int y, int bw, int bh, bit [63:0] v, inout int n);
      pix_t p;
      if (x >= bw || y >= bh) return;
      p.idx = (y * bw + x) & 32'hfffff;
      p.val = v;
      p.last = 0;
      due.push_back(p);
      n++;
    endfunction

    function void note_input(bit [1:0] cmd, bit [13:0] pi, bit [15:0] pv, bit [63:0] c);
      int w, h, tw, th, nch, kk, n;
      bit [15:0] wd;
      bit [7:0] by;
      bit [3:0] nib;
      bit [63:0] v;
      w = dim(wreg); h = dim(hreg); n = 0;
      if (cmd == CMD_PAL) begin
        pal[pi] = pv;
        return;
      end
      if (cmd == CMD_BEGIN) begin
        left = 0; top = 0; k = 0;
        return;
      end
      if (cmd != CMD_CHUNK) return;
      case (fmt)
        FMT_I4, FMT_C4, FMT_DXT1: begin tw = 8; th = 8; nch = 4; end
        FMT_I8, FMT_IA4, FMT_C8: begin tw = 8; th = 4; nch = 4; end
        FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_C14: begin tw = 4; th = 4; nch = 4; end
        FMT_RGBA8: begin tw = 4; th = 4; nch = 8; end
        default: return;
      endcase
      if (top >= h) return;
      kk = k % nch;
      case (fmt)
        FMT_I4, FMT_C4:
          for (int i = 0; i < 16; i++) begin
            nib = c[60-4*i +: 4];
            v = (fmt == FMT_I4) ? {nib, nib} : lookup(nib);
            place(left + i % 8, top + 2 * kk + i / 8, w, h, v, n);
          end
        FMT_I8, FMT_IA4, FMT_C8:
          for (int i = 0; i < 8; i++) begin
            by = c[56-8*i +: 8];
            v = (fmt == FMT_C8) ? lookup(by) : by;
            place(left + i, top + kk, w, h, v, n);
          end
        FMT_RGBA8:
          for (int i = 0; i < 4; i++) begin
            wd = c[48-16*i +: 16];
            if (kk < 4) begin
              hold[kk*4+i] = wd;
              hold_seen[kk*4+i] = 1;
            end else begin
              place(left + i, top + kk - 4, w, h, {hold[(kk-4)*4+i], wd}, n);
            end
          end
        FMT_DXT1: begin
          v = {c[55:48], c[63:56], c[39:32], c[47:40], flip_pairs(c[31:24]),
               flip_pairs(c[23:16]), flip_pairs(c[15:8]), flip_pairs(c[7:0])};
          place(left / 4 + kk % 2, top / 4 + kk / 2, (w + 3) / 4, (h + 3) / 4, v, n);
        end
        default:
          for (int i = 0; i < 4; i++) begin
            wd = c[48-16*i +: 16];
            if (fmt == FMT_RGB5A3) v = widen5a3(wd);
            else if (fmt == FMT_C14) v = lookup(wd[13:0]);
            else v = wd;
            place(left + i, top + kk, w, h, v, n);
          end
      endcase
      kk++;
      if (kk >= nch) begin
        kk = 0;
        left += tw;
        if (left >= w) begin left = 0; top += th; end
      end
      k = kk;
      if (n > 0) due[due.size()-1].last = 1;
    endfunction

    task check_result(bit [19:0] idx, bit [63:0] val, bit last);
      pix_t e;
      if (due.size() == 0) begin
        report($sformatf("unexpected pixel idx %0d val %h", idx, val));
        return;
      end
      e = due.pop_front();
      if (idx != e.idx) report($sformatf("pixel_index %0d, want %0d", idx, e.idx));
      if (val != e.val) report($sformatf("pixel_value %h, want %h (idx %0d)", val, e.val, e.idx));
      if (last != e.last) report($sformatf("last %0b, want %0b (idx %0d)", last, e.last, e.idx));
    endtask
  endclass

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  in_cmd;
  logic [13:0] in_palette_index;
  logic [15:0] in_palette_value;
  logic [63:0] in_source_chunk;
  logic        out_valid, out_stall;
  logic [19:0] out_pixel_index;
  logic [63:0] out_pixel_value;
  logic        out_last;

  pixel_scoreboard sb;
  bit              quiet;
  int              stall_left;
  int              pal_used[$];
  int              rand_items;

  tiled_texture_detile_decode_core dut (.*);

  initial clk = 0;
  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Random receiver stall bursts; none once the run goes quiet.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 0;
    end
  end

  // Inputs only move at the rising edge, so the beat is settled here.
  always @(negedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_pixel_index, out_pixel_value, out_last);

  task send_beat(bit [1:0] cmd, bit [13:0] pi, bit [15:0] pv, bit [63:0] ch);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= cmd;
    in_palette_index <= pi;
    in_palette_value <= pv;
    in_source_chunk <= ch;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    sb.note_input(cmd, pi, pv, ch);
  endtask

  task write_palette(bit [13:0] pi, bit [15:0] pv);
    send_beat(CMD_PAL, pi, pv, {$urandom, $urandom});
    pal_used.push_back(pi);
  endtask

  task drain;
    in_valid <= 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last register.
  task write_reg(bit [1:0] r, bit [10:0] d);
    cfg_we <= 1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(r, d);
  endtask

  task setup_image(bit [3:0] f, bit [10:0] w, bit [10:0] h, bit [1:0] pf, bit restart);
    drain();
    write_reg(REG_TEXEL, {$urandom_range(0, 127), f});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_PFMT, {$urandom_range(0, 511), pf});
    cfg_we <= 0;
    if (restart) send_beat(CMD_BEGIN, $urandom, $urandom, {$urandom, $urandom});
  endtask

  function bit [63:0] make_chunk(bit [3:0] f);
    bit [63:0] c;
    c = {$urandom, $urandom};
    if (f == FMT_C14)
      for (int i = 0; i < 4; i++)
        c[16*i +: 14] = pal_used[$urandom_range(0, pal_used.size() - 1)];
    return c;
  endfunction

  function int chunk_count(bit [3:0] f, int w, int h);
    int tw, th, nch;
    tw = 4; th = 4; nch = 4;
    case (f)
      FMT_I4, FMT_C4, FMT_DXT1: begin tw = 8; th = 8; end
      FMT_I8, FMT_IA4, FMT_C8: tw = 8;
      FMT_RGBA8: nch = 8;
      default: ;
    endcase
    return ((w + tw - 1) / tw) * ((h + th - 1) / th) * nch;
  endfunction

  bit [3:0] fmts[11] = '{FMT_I4, FMT_I8, FMT_IA4, FMT_IA8, FMT_RGB565, FMT_RGB5A3,
                          FMT_RGBA8, FMT_C4, FMT_C8, FMT_C14, FMT_DXT1};

  initial begin
    bit [3:0]  f;
    bit [10:0] w, h;
    int        n, sel;
    bit        restart;
    sb = new();
    rst_n <= 0;
    cfg_we <= 0; cfg_index <= 0; cfg_data <= 0;
    in_valid <= 0; in_cmd <= 0; in_palette_index <= 0; in_palette_value <= 0;
    in_source_chunk <= 0;
    quiet = 0;
    rand_items = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Load the low palette plus the top entries so every lookup hits a written entry.
    for (int i = 0; i < 256; i++) write_palette(i, $urandom);
    write_palette(14'h3fff, 16'hffff);
    write_palette(14'h2000, 16'h8000);
    write_palette(14'h1fff, 16'h7fff);

    // Directed: one tile of each format, zero and all-ones content, plus a stray command.
    foreach (fmts[j]) begin
      setup_image(fmts[j], 8, 8, j % 4, 1);
      n = (fmts[j] == FMT_RGBA8) ? 8 : 4;
      for (int i = 0; i < n; i++)
        send_beat(CMD_CHUNK, 0, 0, (i % 2) ? make_chunk(fmts[j]) | ~64'h0 & (
          fmts[j] == FMT_C14 ? 64'hc000_c000_c000_c000 : ~64'h0) : 64'h0);
    end
    setup_image(4'd7, 8, 8, PFMT_RGB5A3, 1);
    send_beat(CMD_CHUNK, 0, 0, ~64'h0);
    send_beat(2'd3, 14'h3fff, 16'hffff, ~64'h0);

    // Random images: mostly well-formed streams, some noise and broken ones.
    while (rand_items < 100) begin
      sel = $urandom_range(0, 19);
      f = (sel == 0) ? 4'd7 + 4 * $urandom_range(0, 2) : fmts[$urandom_range(0, 10)];
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 24);
      case ($urandom_range(0, 11))
        0: begin w = 0; h = $urandom_range(0, 4); end
        1: begin w = 1024; h = $urandom_range(1, 4); end
        2: begin w = 2047; h = 1; end
        3: begin w = $urandom_range(1, 4); h = 1024; end
        4: begin w = 1; h = 2047; end
        default: ;
      endcase
      restart = (f != FMT_RGBA8 || sb.hold_seen == 16'hffff) ? $urandom_range(0, 5) != 0 : 1;
      setup_image(f, w, h, $urandom_range(0, 3), restart);
      n = (sel == 0) ? 6 : chunk_count(f, sb.dim(w), sb.dim(h)) + $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        if (rand_items >= 100) break;
        if (rand_items > 80) quiet = 1;
        case ($urandom_range(0, 24))
          0: send_beat(2'd3, $urandom, $urandom, {$urandom, $urandom});
          1: write_palette($urandom, $urandom);
          2: send_beat(CMD_BEGIN, $urandom, $urandom, {$urandom, $urandom});
          default: ;
        endcase
        send_beat(CMD_CHUNK, $urandom, $urandom, make_chunk(f));
        rand_items++;
      end
    end

    drain();
    if (sb.due.size() != 0) sb.report($sformatf("%0d pixels never arrived", sb.due.size()));
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
